@@ hdl/assert_macros.svh @@
// Assertion macros shared by the slot tracker RTL.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define HCST_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define HCST_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define HCST_ASSERT(label, clk, rst_n, prop)
`define HCST_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ hdl/hcst_pkg.sv @@
// Types and codes for the health check slot tracker.
// No dependencies; imported by health_check_slot_tracker.
package hcst_pkg;

	// Request operation codes
	localparam logic [1:0] OP_CLAIM = 2'd0;
	localparam logic [1:0] OP_PASS  = 2'd1;
	localparam logic [1:0] OP_FAIL  = 2'd2;

	// Configuration register indexes (word address)
	localparam logic [1:0] REG_MASK      = 2'd0;
	localparam logic [1:0] REG_INTERVAL  = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_DURATION  = 2'd3;

	// Reset values of the configuration registers
	localparam logic [15:0] MASK_RST      = 16'd0;
	localparam logic [31:0] INTERVAL_RST  = 32'd1000;
	localparam logic [15:0] THRESHOLD_RST = 16'd3;
	localparam logic [31:0] DURATION_RST  = 32'd60000;

	// Hardware slots never exceed the width of the enable mask
	localparam int MASK_SLOTS = 16;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLAIM,
		ST_PASS,
		ST_FAIL_CNT,
		ST_FAIL_BL,
		ST_FIN
	} state_t;

	// Shared adder control
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} unit_ctl_t;

endpackage

@@ hdl/health_check_slot_tracker.sv @@
// Health check slot tracker: top level with sequencer, slot state and APB registers.
// Depends on hcst_pkg and assert_macros.svh.
//
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    op, slot, now_ms
// out       result     out_valid / out_ready  claimed, claimed_slot, next_due_wait,
//                                             blacklist_raised
// cfg       APB write  psel&penable&pwrite    paddr, pwdata (prdata on read)
//
// One request at a time. Claim walks the slots one per cycle through a shared
// 32-bit add/subtract unit over min(SLOTS,16) slots, then takes a claim step if a
// slot is due. Pass has an update step; fail a count step and, at threshold, a blacklist step.
// A finished result sits in an output register; the next request is taken while
// it waits. Reset clears all slot state and loads register defaults at once.
`include "assert_macros.svh"

module health_check_slot_tracker
	import hcst_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [31:0] now_ms,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        claimed,
	output logic [3:0]  claimed_slot,
	output logic [31:0] next_due_wait,
	output logic        blacklist_raised,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Only slots below the mask width can ever be enabled
	localparam int ACT_SLOTS = (SLOTS < MASK_SLOTS) ? SLOTS : MASK_SLOTS;
	localparam int IDX_W     = (ACT_SLOTS > 1) ? $clog2(ACT_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ACT_SLOTS - 1);

	// Configuration registers
	logic [15:0] mask_q;
	logic [31:0] interval_q;
	logic [15:0] threshold_q;
	logic [31:0] duration_q;

	// Per-slot state
	logic [ACT_SLOTS-1:0] busy_q;
	logic [31:0]          next_q [ACT_SLOTS];
	logic [15:0]          cnt_q  [ACT_SLOTS];
	logic [31:0]          dl_q   [ACT_SLOTS];

	// Sequencer and working registers
	state_t          state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]     now_q;
	logic [31:0]     soonest_q;
	logic            res_claimed_q;
	logic [3:0]      res_slot_q;
	logic [31:0]     res_wait_q;
	logic            res_newly_q;

	// Output register
	logic            out_valid_q;
	logic            claimed_q;
	logic [3:0]      claimed_slot_q;
	logic [31:0]     next_due_wait_q;
	logic            newly_q;

	// Combinational helpers
	logic                 in_fire;
	logic                 cfg_wr;
	logic                 out_free;
	logic                 slot_ok;
	logic [ACT_SLOTS-1:0] en_vec;
	logic                 cur_en;
	logic                 cur_busy;
	logic [31:0]          cur_next;
	logic [15:0]          cur_cnt;
	logic [31:0]          cur_dl;
	unit_ctl_t            unit;
	logic [32:0]          unit_sum;
	logic                 unit_carry;
	logic [31:0]          unit_sat;
	logic                 due;
	logic                 scan_elig;
	logic                 scan_take;
	logic                 scan_last;
	logic [31:0]          soon_nx;
	logic [15:0]          cnt_inc;
	logic                 fail_hit;

	// Handshakes
	assign in_fire  = in_valid && in_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || out_ready;
	assign pready   = 1'b1;

	// Addressed pass/fail slot must exist and be enabled
	assign slot_ok = ({1'b0, slot} < 5'(ACT_SLOTS)) && mask_q[slot];

	// Slot read port, shared by scan and pass/fail
	assign en_vec   = mask_q[ACT_SLOTS-1:0];
	assign cur_en   = en_vec[idx_q];
	assign cur_busy = busy_q[idx_q];
	assign cur_next = next_q[idx_q];
	assign cur_cnt  = cnt_q[idx_q];
	assign cur_dl   = dl_q[idx_q];

	// Shared adder: a + b, or a - b with carry meaning no borrow
	assign unit_sum   = {1'b0, unit.a} + {1'b0, (unit.sub ? ~unit.b : unit.b)}
		+ 33'(unit.sub);
	assign unit_carry = unit_sum[32];
	assign unit_sat   = unit_carry ? '1 : unit_sum[31:0];

	// Scan step: due when next check time is not after now
	assign due       = !(unit_carry && (unit_sum[31:0] != '0));
	assign scan_elig = cur_en && !cur_busy;
	assign scan_take = scan_elig && due;
	assign scan_last = (idx_q == LAST_IDX);
	assign soon_nx   = (scan_elig && !due && (unit_sum[31:0] < soonest_q))
		? unit_sum[31:0] : soonest_q;

	// Failure count, saturating, and threshold check
	assign cnt_inc  = (&cur_cnt) ? cur_cnt : cur_cnt + 16'd1;
	assign fail_hit = (threshold_q != '0) && (cnt_inc >= threshold_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (op)
						OP_CLAIM: state_d = ST_SCAN;
						OP_PASS:  state_d = slot_ok ? ST_PASS : ST_FIN;
						OP_FAIL:  state_d = slot_ok ? ST_FAIL_CNT : ST_FIN;
						default:  state_d = ST_FIN;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_take) begin
					state_d = ST_CLAIM;
				end else if (scan_last) begin
					state_d = ST_FIN;
				end
			end
			ST_CLAIM:    state_d = ST_FIN;
			ST_PASS:     state_d = ST_FIN;
			ST_FAIL_CNT: state_d = fail_hit ? ST_FAIL_BL : ST_FIN;
			ST_FAIL_BL:  state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: ready and adder operands
	always_comb begin
		in_ready = 1'b0;
		unit.a   = now_q;
		unit.b   = interval_q;
		unit.sub = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: begin
				unit.a   = cur_next;
				unit.b   = now_q;
				unit.sub = 1'b1;
			end
			ST_FAIL_BL: unit.b = duration_q;
			default: begin
			end
		endcase
	end

	// Control state and slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			busy_q      <= '0;
			for (int i = 0; i < ACT_SLOTS; i++) begin
				next_q[i] <= '0;
				cnt_q[i]  <= '0;
				dl_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;

			// index: start of scan or addressed slot
			if (in_fire) begin
				idx_q <= (op == OP_CLAIM) ? '0 : slot[IDX_W-1:0];
			end else if (state_q == ST_SCAN && !scan_take && !scan_last) begin
				idx_q <= idx_q + 1'b1;
			end

			// slot table updates
			case (state_q)
				ST_CLAIM: begin
					busy_q[idx_q] <= 1'b1;
					next_q[idx_q] <= unit_sat;
				end
				ST_PASS: begin
					busy_q[idx_q] <= 1'b0;
					cnt_q[idx_q]  <= '0;
					if (cur_cnt != '0) begin
						dl_q[idx_q] <= '0;
					end
				end
				ST_FAIL_CNT: begin
					busy_q[idx_q] <= 1'b0;
					cnt_q[idx_q]  <= cnt_inc;
				end
				ST_FAIL_BL: begin
					if (cur_dl < unit_sat) begin
						dl_q[idx_q] <= unit_sat;
					end
				end
				default: begin
				end
			endcase

			// output register valid
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q         <= now_ms;
			soonest_q     <= interval_q;
			res_claimed_q <= 1'b0;
			res_slot_q    <= '0;
			res_wait_q    <= '0;
			res_newly_q   <= 1'b0;
		end
		case (state_q)
			ST_SCAN: begin
				soonest_q <= soon_nx;
				if (!scan_take && scan_last) begin
					res_wait_q <= soon_nx;
				end
			end
			ST_CLAIM: begin
				res_claimed_q <= 1'b1;
				res_slot_q    <= 4'(idx_q);
				res_wait_q    <= interval_q;
			end
			ST_FAIL_BL: begin
				if (cur_dl < unit_sat) begin
					res_newly_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_FIN && out_free) begin
			claimed_q       <= res_claimed_q;
			claimed_slot_q  <= res_slot_q;
			next_due_wait_q <= res_wait_q;
			newly_q         <= res_newly_q;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= MASK_RST;
			interval_q  <= INTERVAL_RST;
			threshold_q <= THRESHOLD_RST;
			duration_q  <= DURATION_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MASK:      mask_q      <= pwdata[15:0];
				REG_INTERVAL:  interval_q  <= pwdata;
				REG_THRESHOLD: threshold_q <= pwdata[15:0];
				REG_DURATION:  duration_q  <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_MASK:      prdata = {16'd0, mask_q};
			REG_INTERVAL:  prdata = interval_q;
			REG_THRESHOLD: prdata = {16'd0, threshold_q};
			REG_DURATION:  prdata = duration_q;
			default:       prdata = '0;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign claimed           = claimed_q;
	assign claimed_slot      = claimed_slot_q;
	assign next_due_wait     = next_due_wait_q;
	assign blacklist_raised  = newly_q;

	// Checks
	`HCST_ASSERT(a_busy_after_accept, clk, arst_n, in_fire |=> !in_ready)
	`HCST_ASSERT(a_claim_reports_interval, clk, arst_n,
		(out_valid_q && claimed_q) |-> (next_due_wait_q == interval_q))
	`HCST_ASSERT(a_no_slot_without_claim, clk, arst_n,
		(out_valid_q && !claimed_q) |-> (claimed_slot_q == '0))
	`HCST_NEVER(a_claim_and_blacklist, clk, arst_n, out_valid_q && claimed_q && newly_q)
	`HCST_ASSERT(a_claim_marks_busy, clk, arst_n, (state_q == ST_CLAIM) |=> busy_q[$past(idx_q)])

endmodule
